@@ hw/rtl/bgd_pkg.sv @@
// Shared types, constants and register codes for the button gesture decoder.
package bgd_pkg;

    localparam int TS_W    = 32;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int GEST_W  = 3;
    localparam int TAP_W   = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HOLD     = 2'd1;
    localparam logic [CIDX_W-1:0] REG_TAPWIN   = 2'd2;

    // Reset values of the configuration registers (ms)
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd600;
    localparam logic [CFG_W-1:0] TAPWIN_RST   = 16'd350;

    // Gesture codes
    localparam logic [GEST_W-1:0] G_NONE         = 3'd0;
    localparam logic [GEST_W-1:0] G_HOLD         = 3'd1;
    localparam logic [GEST_W-1:0] G_HOLD_RELEASE = 3'd2;
    localparam logic [GEST_W-1:0] G_SINGLE       = 3'd3;
    localparam logic [GEST_W-1:0] G_DOUBLE       = 3'd4;
    localparam logic [GEST_W-1:0] G_TRIPLE       = 3'd5;

    localparam logic [TAP_W-1:0] TAP_MAX = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] hold_time;
        logic [CFG_W-1:0] tap_window;
    } t_cfg;

endpackage

@@ hw/rtl/bgd_if.sv @@
// Valid/ready channel interfaces for poll items and gesture results.
interface bgd_item_if;
    import bgd_pkg::*;
    logic            valid;
    logic            ready;
    logic            pressed_level;
    logic [TS_W-1:0] timestamp;

    modport source (output valid, output pressed_level, output timestamp, input ready);
    modport sink   (input valid, input pressed_level, input timestamp, output ready);
endinterface

interface bgd_result_if;
    import bgd_pkg::*;
    logic              valid;
    logic              ready;
    logic [GEST_W-1:0] gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

@@ hw/rtl/bgd_cfg_regs.sv @@
// Configuration register file: debounce, hold and tap window thresholds.
module bgd_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bgd_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [bgd_pkg::CFG_W-1:0]  i_cfg_wdata,
    output bgd_pkg::t_cfg              o_cfg
);
    import bgd_pkg::*;

    t_cfg r_cfg;

    // Write decode; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= DEBOUNCE_RST;
            r_cfg.hold_time     <= HOLD_RST;
            r_cfg.tap_window    <= TAPWIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE: r_cfg.debounce_time <= i_cfg_wdata;
                REG_HOLD:     r_cfg.hold_time     <= i_cfg_wdata;
                REG_TAPWIN:   r_cfg.tap_window    <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/bgd_core.sv @@
// Gesture state and the single-pass decode of one poll.
module bgd_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bgd_pkg::t_cfg              i_cfg,
    input  logic                       i_fire,
    input  logic                       i_level,
    input  logic [bgd_pkg::TS_W-1:0]   i_now,
    output logic [bgd_pkg::GEST_W-1:0] o_gesture
);
    import bgd_pkg::*;

    logic             r_last_raw,   n_last_raw;
    logic [TS_W-1:0]  r_chg_time,   n_chg_time;
    logic             r_stable,     n_stable;
    logic [TS_W-1:0]  r_press_time, n_press_time;
    logic             r_hold_rep,   n_hold_rep;
    logic [TAP_W-1:0] r_taps,       n_taps;
    logic [TS_W-1:0]  r_rel_time,   n_rel_time;

    logic             edge_det;
    logic             release_det;
    logic             hold_fire;
    logic [TAP_W-1:0] taps_inc;
    logic [TS_W-1:0]  deb_age;
    logic [TS_W-1:0]  press_age;
    logic [TS_W-1:0]  rel_age;

    // Debounce, hold detection, tap counting and tap-run resolution
    always_comb begin
        n_last_raw   = i_level;
        n_chg_time   = (i_level != r_last_raw) ? i_now : r_chg_time;
        deb_age      = i_now - n_chg_time;
        edge_det     = (deb_age >= {{(TS_W-CFG_W){1'b0}}, i_cfg.debounce_time})
                       && (i_level != r_stable);
        n_stable     = edge_det ? i_level : r_stable;
        release_det  = edge_det && !i_level;

        n_press_time = (edge_det && i_level) ? i_now : r_press_time;
        n_hold_rep   = (edge_det && i_level) ? 1'b0 : r_hold_rep;
        press_age    = i_now - n_press_time;
        hold_fire    = n_stable && !n_hold_rep
                       && (press_age >= {{(TS_W-CFG_W){1'b0}}, i_cfg.hold_time});

        n_taps       = r_taps;
        n_rel_time   = r_rel_time;
        taps_inc     = (r_taps == TAP_MAX) ? TAP_MAX : r_taps + 1'b1;
        rel_age      = '0;
        o_gesture    = G_NONE;

        if (hold_fire) begin
            n_hold_rep = 1'b1;
            n_taps     = '0;
            o_gesture  = G_HOLD;
        end else if (release_det && n_hold_rep) begin
            o_gesture  = G_HOLD_RELEASE;
        end else begin
            if (release_det) begin
                n_taps     = taps_inc;
                n_rel_time = i_now;
            end
            rel_age = i_now - n_rel_time;
            if ((n_taps != '0) && !n_stable
                && (rel_age >= {{(TS_W-CFG_W){1'b0}}, i_cfg.tap_window})) begin
                case (n_taps)
                    2'd1:    o_gesture = G_SINGLE;
                    2'd2:    o_gesture = G_DOUBLE;
                    default: o_gesture = G_TRIPLE;
                endcase
                n_taps = '0;
            end
        end
    end

    // State update once per decoded poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw   <= 1'b0;
            r_chg_time   <= '0;
            r_stable     <= 1'b0;
            r_press_time <= '0;
            r_hold_rep   <= 1'b0;
            r_taps       <= '0;
            r_rel_time   <= '0;
        end else if (i_fire) begin
            r_last_raw   <= n_last_raw;
            r_chg_time   <= n_chg_time;
            r_stable     <= n_stable;
            r_press_time <= n_press_time;
            r_hold_rep   <= n_hold_rep;
            r_taps       <= n_taps;
            r_rel_time   <= n_rel_time;
        end
    end

endmodule

@@ hw/rtl/button_gesture_decoder.sv @@
// Button gesture decoder top level: input register, decode core, result register.
// Each beat on i_item is one poll of the raw button level with its millisecond
// timestamp; every poll yields exactly one beat on o_result whose gesture is
// none, hold, hold release, or single/double/triple tap. A poll is registered in the input
// register, decoded against the gesture state and written to the result register,
// and one poll is taken every cycle while the result side keeps up. Thresholds are
// to be written through the plain configuration port (index 0 debounce, 1 hold, 2 tap
// window) only while idle; the block itself does not enforce this.
module button_gesture_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bgd_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [bgd_pkg::CFG_W-1:0]  i_cfg_wdata,
    bgd_item_if.sink                   i_item,
    bgd_result_if.source               o_result
);
    import bgd_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic              r_in_level;
    logic [TS_W-1:0]   r_in_ts;
    logic              r_out_valid;
    logic [GEST_W-1:0] r_out_gesture;
    logic [GEST_W-1:0] core_gesture;
    logic              advance;
    logic              core_fire;

    bgd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Pipeline moves when the result register is free or being drained
    assign advance      = !r_out_valid || o_result.ready;
    assign core_fire    = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_level <= i_item.pressed_level;
            r_in_ts    <= i_item.timestamp;
        end
    end

    bgd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_fire    (core_fire),
        .i_level   (r_in_level),
        .i_now     (r_in_ts),
        .o_gesture (core_gesture)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_fire) begin
            r_out_gesture <= core_gesture;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.gesture = r_out_gesture;

    // A decoded poll always lands in the result register
    a_fire_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_fire |=> r_out_valid)
        else $error("decoded beat did not reach result register");

    // A stalled poll stays put in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_ts)
                                   && $stable(r_in_level))
        else $error("input register lost a stalled beat");

    // No new poll is taken while the pipeline is blocked
    a_no_accept_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_result.ready |-> !i_item.ready)
        else $error("poll accepted while pipeline blocked");

endmodule

@@ test/gesture_checker.sv @@
// Gesture checker: watches both channels, predicts each gesture and compares it.
`timescale 1ns / 1ps

module gesture_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bgd_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [bgd_pkg::CFG_W-1:0]  i_cfg_wdata,
    bgd_item_if                        item_mon,
    bgd_result_if                      result_mon,
    output int                         o_errors,
    output int                         o_pending
);
    import bgd_pkg::*;

    // Predicted thresholds and gesture state
    t_cfg              thresholds;
    logic              raw_q;
    logic [TS_W-1:0]   raw_change_ts;
    logic              stable_q;
    logic [TS_W-1:0]   press_ts;
    logic              hold_seen;
    logic [TAP_W-1:0]  taps;
    logic [TS_W-1:0]   release_ts;

    logic [GEST_W-1:0] expected_gestures[$];
    logic [GEST_W-1:0] want;
    int                mismatches = 0;
    int                outstanding = 0;

    assign o_errors  = mismatches;
    assign o_pending = outstanding;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // One poll through the debounce and gesture rules; all ages wrap at 32 bits
    function automatic logic [GEST_W-1:0] decode_poll(input logic lvl,
                                                      input logic [TS_W-1:0] now_ms);
        logic            settled;
        logic [TS_W-1:0] age;
        logic [GEST_W-1:0] run_code;
        settled = 1'b0;
        if (lvl != raw_q) begin
            raw_q         = lvl;
            raw_change_ts = now_ms;
        end
        age = now_ms - raw_change_ts;
        if (age >= {16'b0, thresholds.debounce_time} && lvl != stable_q) begin
            stable_q = lvl;
            settled  = 1'b1;
        end
        if (settled && stable_q) begin
            press_ts  = now_ms;
            hold_seen = 1'b0;
        end
        // hold wins over anything else on the same poll
        age = now_ms - press_ts;
        if (stable_q && !hold_seen && age >= {16'b0, thresholds.hold_time}) begin
            hold_seen = 1'b1;
            taps      = '0;
            return G_HOLD;
        end
        if (settled && !stable_q) begin
            if (hold_seen)
                return G_HOLD_RELEASE;
            if (taps < TAP_MAX)
                taps = taps + 1'b1;
            release_ts = now_ms;
        end
        // resolve the tap run once the window has passed with the button up
        age = now_ms - release_ts;
        if (taps != '0 && !stable_q && age >= {16'b0, thresholds.tap_window}) begin
            case (taps)
                2'd1:    run_code = G_SINGLE;
                2'd2:    run_code = G_DOUBLE;
                default: run_code = G_TRIPLE;
            endcase
            taps = '0;
            return run_code;
        end
        return G_NONE;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thresholds.debounce_time = DEBOUNCE_RST;
            thresholds.hold_time     = HOLD_RST;
            thresholds.tap_window    = TAPWIN_RST;
            raw_q         = 1'b0;
            raw_change_ts = '0;
            stable_q      = 1'b0;
            press_ts      = '0;
            hold_seen     = 1'b0;
            taps          = '0;
            release_ts    = '0;
            expected_gestures.delete();
        end else begin
            // result side: compare against the oldest prediction
            if (result_mon.valid && result_mon.ready) begin
                if (expected_gestures.size() == 0) begin
                    report_mismatch($sformatf("gesture %0d with no poll outstanding",
                                              result_mon.gesture));
                end else begin
                    want = expected_gestures.pop_front();
                    if (result_mon.gesture !== want)
                        report_mismatch($sformatf("gesture %0d, predicted %0d",
                                                  result_mon.gesture, want));
                end
            end
            // threshold writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEBOUNCE: thresholds.debounce_time = i_cfg_wdata;
                    REG_HOLD:     thresholds.hold_time     = i_cfg_wdata;
                    REG_TAPWIN:   thresholds.tap_window    = i_cfg_wdata;
                    default:      ;
                endcase
            end
            // poll side: predict the gesture for each accepted beat
            if (item_mon.valid && item_mon.ready)
                expected_gestures.push_back(decode_poll(item_mon.pressed_level,
                                                        item_mon.timestamp));
        end
        outstanding = expected_gestures.size();
    end

endmodule

@@ test/tb.sv @@
// Testbench top: clock, reset, poll stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
    import bgd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_POLLS    = 220;
    localparam int NUM_PHASES     = 8;
    localparam int SQUEEZE_AFTER  = 700;
    localparam int SQUEEZE_CYCLES = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]  cfg_wdata;
    int                errors;
    int                pending;

    bgd_item_if   item_ch ();
    bgd_result_if result_ch ();

    button_gesture_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    gesture_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .item_mon    (item_ch),
        .result_mon  (result_ch),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Stimulus-side view of time and thresholds
    logic [TS_W-1:0] now_ms;
    int unsigned     deb_ms;
    int unsigned     hold_ms;
    int unsigned     win_ms;
    int unsigned     step_ms;
    bit              tx_calm;
    bit              rx_calm;
    int              result_beats;
    int              idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 96)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Offer one poll; valid stays high after the beat until the next call
    task automatic send_poll(input logic lvl, input logic [TS_W-1:0] ts);
        int gap;
        gap = pick_gap(tx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.pressed_level <= lvl;
        item_ch.timestamp     <= ts;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic poll_after(input logic lvl, input logic [TS_W-1:0] dt, inout int sent);
        now_ms = now_ms + dt;
        send_poll(lvl, now_ms);
        sent++;
    endtask

    // Stable level for at least dur_ms, polled at random spacing
    task automatic run_level(input logic lvl, input int unsigned dur_ms, inout int sent);
        int unsigned elapsed;
        int unsigned dt;
        elapsed = 0;
        do begin
            dt = $urandom_range(1, step_ms);
            poll_after(lvl, dt, sent);
            elapsed += dt;
        end while (elapsed < dur_ms);
    endtask

    // Contact chatter ahead of settling on lvl
    task automatic chatter(input logic lvl, inout int sent);
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            poll_after((i % 2 == 0) ? lvl : ~lvl, $urandom_range(0, deb_ms / 3 + 1), sent);
    endtask

    // Drop valid and wait until every predicted gesture has come back
    task automatic drain;
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_thresholds(input int unsigned d, input int unsigned h,
                                  input int unsigned w);
        int unsigned widest;
        write_reg(REG_DEBOUNCE, d);
        write_reg(REG_HOLD, h);
        write_reg(REG_TAPWIN, w);
        deb_ms  = d;
        hold_ms = h;
        win_ms  = w;
        widest  = (d > h) ? d : h;
        widest  = (widest > w) ? widest : w;
        step_ms = (widest / 6 > 0) ? widest / 6 : 1;
    endtask

    // Mostly well-formed tap runs and holds, with some wander and wild jumps
    task automatic random_phase(input int target);
        int sent;
        int r;
        int k;
        sent = 0;
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) begin
                    chatter(1'b1, sent);
                    run_level(1'b1, $urandom_range(1, deb_ms + hold_ms * 3 / 4 + 2), sent);
                    chatter(1'b0, sent);
                    run_level(1'b0, $urandom_range(1, deb_ms + win_ms / 2 + 2), sent);
                end
                run_level(1'b0, $urandom_range(1, deb_ms + win_ms * 2 + 2), sent);
            end else if (r < 70) begin
                chatter(1'b1, sent);
                run_level(1'b1, $urandom_range(deb_ms + hold_ms,
                                               deb_ms + hold_ms + hold_ms / 2 + step_ms + 2),
                          sent);
                chatter(1'b0, sent);
                run_level(1'b0, $urandom_range(1, deb_ms + win_ms + 2), sent);
            end else if (r < 88) begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                    poll_after(1'($urandom_range(0, 1)), $urandom_range(0, step_ms * 2),
                               sent);
            end else begin
                // timestamps jump anywhere, including backwards
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    poll_after(1'($urandom_range(0, 1)), $urandom(), sent);
            end
        end
    endtask

    // Result side: random stalls, one long squeeze to back up the decoder
    initial begin
        int  stall;
        bit  squeezed;
        squeezed        = 1'b0;
        result_beats    = 0;
        result_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = pick_gap(rx_calm);
            if (!squeezed && result_beats >= SQUEEZE_AFTER) begin
                stall    = SQUEEZE_CYCLES;
                squeezed = 1'b1;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
            result_beats++;
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready)
            || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        int unsigned phase_deb  [NUM_PHASES];
        int unsigned phase_hold [NUM_PHASES];
        int unsigned phase_win  [NUM_PHASES];
        phase_deb  = '{5, 0, 65535, 30, 0, 65535, 0, 0};
        phase_hold = '{40, 0, 65535, 600, 25, 0, 0, 0};
        phase_win  = '{20, 0, 65535, 350, 65535, 0, 0, 0};
        for (int p = 6; p < NUM_PHASES; p++) begin
            phase_deb[p]  = $urandom_range(0, 20);
            phase_hold[p] = $urandom_range(0, 200);
            phase_win[p]  = $urandom_range(0, 120);
        end

        tx_calm               = 1'b0;
        rx_calm               = 1'b0;
        now_ms                = '0;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = REG_DEBOUNCE;
        cfg_wdata             = '0;
        item_ch.valid         = 1'b0;
        item_ch.pressed_level = 1'b0;
        item_ch.timestamp     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero debounce, every gesture, tap saturation, wrap and reorder
        set_thresholds(0, 100, 50);
        send_poll(1'b1, 32'd0);
        send_poll(1'b0, 32'd10);
        send_poll(1'b1, 32'd20);
        send_poll(1'b0, 32'd30);
        send_poll(1'b1, 32'd40);
        send_poll(1'b0, 32'd45);
        send_poll(1'b1, 32'd47);
        send_poll(1'b0, 32'd49);          // fourth tap saturates the count
        send_poll(1'b0, 32'd200);         // triple
        send_poll(1'b1, 32'd300);
        send_poll(1'b1, 32'd450);         // hold
        send_poll(1'b0, 32'd460);         // hold release
        send_poll(1'b1, 32'd470);
        send_poll(1'b0, 32'd480);
        send_poll(1'b0, 32'd600);         // single
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'h0000_0040);   // single across the wrap
        send_poll(1'b1, 32'h0000_0050);
        send_poll(1'b0, 32'h0000_0055);
        send_poll(1'b1, 32'h0000_0058);
        send_poll(1'b0, 32'h0000_005A);
        send_poll(1'b0, 32'h0000_0200);   // double
        send_poll(1'b0, 32'h0000_0100);   // time steps backwards
        drain();

        // Random phases over a range of thresholds, extremes included
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_thresholds(phase_deb[p], phase_hold[p], phase_win[p]);
            now_ms  = $urandom();
            tx_calm = (p % 3 == 1);
            rx_calm = (p % 4 == 2);
            random_phase(PHASE_POLLS);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
